/* rtl/a2lp_pkg.sv */
// Shared types, constants and helper functions for the Annex B to
// length-prefixed converter. No dependencies.
package a2lp_pkg;

  // Output capacity of one converted frame, in bytes.
  localparam int unsigned MAX_FRAME_BYTES = 1048576;
  // Pointer wide enough to hold MAX_FRAME_BYTES itself.
  localparam int unsigned PTR_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned PTR_W1 = PTR_W + 1;
  localparam int unsigned OFF_W  = 21;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ND_W   = 3;   // up to four data writes per command
  localparam int unsigned SLOT_BYTES = 4;

  localparam logic [PTR_W-1:0]  MAX_PTR    = PTR_W'(MAX_FRAME_BYTES);
  localparam logic [PTR_W:0]    MAX_PTR1   = PTR_W1'(MAX_FRAME_BYTES);
  localparam logic [PTR_W-1:0]  SLOT_LIMIT = PTR_W'(MAX_FRAME_BYTES - SLOT_BYTES);
  localparam logic [PTR_W-1:0]  SLOT_INC   = PTR_W'(SLOT_BYTES);

  // Command queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_LEN  = 2'd1,
    KIND_DONE = 2'd2
  } a2lp_kind_e;

  // One classified input byte: everything the back end needs to emit its writes.
  typedef struct packed {
    logic [PTR_W-1:0] wp0;       // pointer before the data writes
    logic             over0;     // overflow flag before this byte
    logic [ND_W-1:0]  nd;        // number of data writes
    logic             has_byte;  // last data write carries data_byte
    logic [7:0]       data_byte;
    logic             pa_en;     // patch of the previous slot (start code)
    logic [PTR_W-1:0] pa_off;
    logic [PTR_W-1:0] pa_len;
    logic             pb_en;     // patch of the open slot at frame end
    logic [PTR_W-1:0] pb_off;
    logic [PTR_W-1:0] pb_len;
    logic             done_en;   // frame done
    logic             fin_over;  // overflow flag after this byte
    logic [PTR_W-1:0] fin_size;
  } a2lp_cmd_t;

  typedef struct packed {
    a2lp_kind_e       kind;
    logic [OFF_W-1:0] offset;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             over;
  } a2lp_res_t;

  function automatic logic [OFF_W-1:0] to_off(input logic [PTR_W-1:0] p);
    logic [PTR_W+OFF_W-1:0] ext;
    ext = {{OFF_W{1'b0}}, p};
    return ext[OFF_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] to_val(input logic [PTR_W-1:0] p);
    logic [PTR_W+VAL_W-1:0] ext;
    ext = {{VAL_W{1'b0}}, p};
    return ext[VAL_W-1:0];
  endfunction

  // Unit length behind a slot: bytes written past the 4-byte slot, or 0.
  function automatic logic [PTR_W-1:0] slot_len(input logic [PTR_W-1:0] wp,
                                                 input logic [PTR_W-1:0] so);
    logic [PTR_W:0] slot_end;
    logic [PTR_W:0] diff;
    slot_end = {1'b0, so} + PTR_W1'(SLOT_BYTES);
    if ({1'b0, wp} >= slot_end) begin
      diff = {1'b0, wp} - slot_end;
    end else begin
      diff = '0;
    end
    return diff[PTR_W-1:0];
  endfunction

endpackage

/* rtl/a2lp_front.sv */
// Front end: accepts stream bytes, tracks zero run, pointer and slot state,
// and turns each byte into at most one command. Depends on a2lp_pkg.
module a2lp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         stream_byte_i,
  input  logic               frame_end_i,
  output logic               push_o,
  output a2lp_pkg::a2lp_cmd_t cmd_o
);
  import a2lp_pkg::*;

  logic [1:0]       zr_q, zr_d;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] so_q, so_d;
  logic             open_q, open_d;
  logic             over_q, over_d;

  logic             is_sc, is_zero;
  logic [ND_W-1:0]  nd_main, nd_total;
  logic [1:0]       zr_main;
  logic [PTR_W:0]   sum1;
  logic             sat1, slot_ovf;
  logic [PTR_W-1:0] wp1, wp2, so2;
  logic             over2, open2;

  always_comb begin
    is_zero  = (stream_byte_i == 8'd0);
    is_sc    = (stream_byte_i == 8'd1) && (zr_q >= 2'd2);
    if (is_zero) begin
      nd_main = (zr_q == 2'd3) ? ND_W'(1) : '0;
      zr_main = (zr_q == 2'd3) ? 2'd3 : zr_q + 2'd1;
    end else if (is_sc) begin
      nd_main = '0;
      zr_main = 2'd0;
    end else begin
      nd_main = ND_W'(zr_q) + ND_W'(1);
      zr_main = 2'd0;
    end
    // held zeros are flushed at frame end
    nd_total = nd_main + (frame_end_i ? ND_W'(zr_main) : '0);
    sum1     = {1'b0, wp_q} + PTR_W1'(nd_total);
    sat1     = (sum1 > MAX_PTR1);
    wp1      = sat1 ? MAX_PTR : sum1[PTR_W-1:0];
    slot_ovf = (wp_q > SLOT_LIMIT);

    if (is_sc) begin
      wp2   = slot_ovf ? MAX_PTR : wp_q + SLOT_INC;
      over2 = over_q | slot_ovf;
      so2   = wp_q;
      open2 = 1'b1;
    end else begin
      wp2   = wp1;
      over2 = over_q | sat1;
      so2   = so_q;
      open2 = open_q;
    end

    cmd_o.wp0       = wp_q;
    cmd_o.over0     = over_q;
    cmd_o.nd        = nd_total;
    cmd_o.has_byte  = !is_zero && !is_sc;
    cmd_o.data_byte = stream_byte_i;
    cmd_o.pa_en     = is_sc && open_q;
    cmd_o.pa_off    = so_q;
    cmd_o.pa_len    = slot_len(wp_q, so_q);
    cmd_o.pb_en     = frame_end_i && open2;
    cmd_o.pb_off    = so2;
    cmd_o.pb_len    = slot_len(wp2, so2);
    cmd_o.done_en   = frame_end_i;
    cmd_o.fin_over  = over2;
    cmd_o.fin_size  = wp2;

    push_o = accept_i && ((nd_total != '0) || cmd_o.pa_en || frame_end_i);

    zr_d   = zr_q;
    wp_d   = wp_q;
    so_d   = so_q;
    open_d = open_q;
    over_d = over_q;
    if (accept_i) begin
      if (frame_end_i) begin
        zr_d   = '0;
        wp_d   = '0;
        so_d   = '0;
        open_d = 1'b0;
        over_d = 1'b0;
      end else begin
        zr_d   = zr_main;
        wp_d   = wp2;
        so_d   = so2;
        open_d = open2;
        over_d = over2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zr_q   <= '0;
      wp_q   <= '0;
      so_q   <= '0;
      open_q <= 1'b0;
      over_q <= 1'b0;
    end else begin
      zr_q   <= zr_d;
      wp_q   <= wp_d;
      so_q   <= so_d;
      open_q <= open_d;
      over_q <= over_d;
    end
  end

endmodule

/* rtl/a2lp_fifo.sv */
// Short command queue between front and back end, register based.
// Depends on a2lp_pkg.
module a2lp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  a2lp_pkg::a2lp_cmd_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output a2lp_pkg::a2lp_cmd_t head_o
);
  import a2lp_pkg::*;

  a2lp_cmd_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + FIFO_AW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + FIFO_AW'(1) : rd_q;
    cnt_d = cnt_q + FIFO_CW'(push_i) - FIFO_CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  ap_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  ap_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("pop from empty queue");

endmodule

/* rtl/a2lp_back.sv */
// Back end: walks the head command through its writes into the output
// register, one result per cycle while the output is ready. Depends on a2lp_pkg.
module a2lp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  a2lp_pkg::a2lp_cmd_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output a2lp_pkg::a2lp_res_t out_o
);
  import a2lp_pkg::*;

  // step codes
  localparam logic [2:0] PH_DATA = 3'd0;
  localparam logic [2:0] PH_PA   = 3'd1;
  localparam logic [2:0] PH_PB   = 3'd2;
  localparam logic [2:0] PH_DONE = 3'd3;
  localparam logic [2:0] PH_END  = 3'd4;

  logic            started_q, started_d;
  logic [2:0]      phase_q, phase_d;
  logic [ND_W-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  a2lp_res_t       out_q, out_d;

  logic [2:0]      first_ph, cur_ph, next_ph, after_data, after_pa, after_pb;
  logic [ND_W-1:0] cur_idx, idx_inc;
  logic [PTR_W:0]  dsum;
  logic            dsat, load;
  logic [PTR_W-1:0] doff;
  logic [7:0]      dval;

  always_comb begin
    after_pb   = head_i.done_en ? PH_DONE : PH_END;
    after_pa   = head_i.pb_en ? PH_PB : after_pb;
    after_data = head_i.pa_en ? PH_PA : after_pa;
    first_ph   = (head_i.nd != '0) ? PH_DATA : after_data;
    cur_ph     = started_q ? phase_q : first_ph;
    cur_idx    = started_q ? idx_q : '0;
    idx_inc    = cur_idx + ND_W'(1);

    dsum = {1'b0, head_i.wp0} + PTR_W1'(cur_idx);
    dsat = (dsum >= MAX_PTR1);
    doff = dsat ? MAX_PTR : dsum[PTR_W-1:0];
    dval = (head_i.has_byte && (idx_inc == head_i.nd)) ? head_i.data_byte : 8'd0;

    out_d      = out_q;
    next_ph    = PH_END;
    unique case (cur_ph)
      PH_DATA: begin
        out_d.kind   = KIND_DATA;
        out_d.offset = to_off(doff);
        out_d.value  = {{(VAL_W-8){1'b0}}, dval};
        out_d.over   = head_i.over0 | dsat;
        next_ph      = (idx_inc < head_i.nd) ? PH_DATA : after_data;
      end
      PH_PA: begin
        out_d.kind   = KIND_LEN;
        out_d.offset = to_off(head_i.pa_off);
        out_d.value  = to_val(head_i.pa_len);
        out_d.over   = head_i.over0;
        next_ph      = after_pa;
      end
      PH_PB: begin
        out_d.kind   = KIND_LEN;
        out_d.offset = to_off(head_i.pb_off);
        out_d.value  = to_val(head_i.pb_len);
        out_d.over   = head_i.fin_over;
        next_ph      = after_pb;
      end
      PH_DONE: begin
        out_d.kind   = KIND_DONE;
        out_d.offset = '0;
        out_d.value  = to_val(head_i.fin_size);
        out_d.over   = head_i.fin_over;
        next_ph      = PH_END;
      end
      default: begin
        out_d.kind   = KIND_DONE;
        out_d.offset = '0;
        out_d.value  = '0;
        out_d.over   = 1'b0;
        next_ph      = PH_END;
      end
    endcase
    out_d.last = (next_ph == PH_END);

    load  = head_valid_i && (!valid_q || out_ready_i);
    pop_o = load && out_d.last;

    started_d = started_q;
    phase_d   = phase_q;
    idx_d     = idx_q;
    valid_d   = valid_q;
    if (load) begin
      valid_d   = 1'b1;
      started_d = !out_d.last;
      phase_d   = next_ph;
      idx_d     = (cur_ph == PH_DATA) ? idx_inc : cur_idx;
    end else begin
      out_d = out_q;
      if (out_ready_i) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      phase_q   <= PH_DATA;
      idx_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      started_q <= started_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

  ap_started_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> head_valid_i) else $error("command in progress left the queue");

  ap_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_q.kind == KIND_DONE) |-> out_q.last)
    else $error("frame done not last result of its byte");

endmodule

/* rtl/annexb_to_length_prefixed_core.sv */
// Top level of the Annex B to length-prefixed converter.
// Depends on a2lp_pkg, a2lp_front, a2lp_fifo, a2lp_back.
//
// Converts one H.264 Annex B frame, received a byte per request with tlast on
// the frame's last byte, into memory write requests: data bytes and 4-byte
// length words at offsets from the frame start, plus a frame done request
// carrying the converted size. Every start code becomes a length slot that
// is patched when the next start code or the frame end arrives; up to three
// zero bytes are held until it is known whether they open a start code.
// Rate: one input byte per cycle while the command queue has room, one result
// request per cycle while the output is ready. The front end classifies each
// byte and queues at most one command for it; the back end emits that
// command's 1 to 6 requests in turn. With the output ready, every request
// beyond the first for a byte holds the back end on that command longer, and
// a byte that causes no request (a held zero, the frame's first start code)
// lets it catch up. The 4-entry command queue absorbs the difference; once
// it is full, from extra requests piling up or from the output being held
// off, the input stalls. A byte's command is registered in the queue and its
// first result in the output register. No clearing pass after reset.
module annexb_to_length_prefixed_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic        s_axis_tlast,   // frame_end
  // write requests
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [20:0] write_offset, [52:21] write_value,
                                      // [53] overflow, [55:54] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] write_kind
  output logic        m_axis_tlast    // run_last
);
  import a2lp_pkg::*;

  logic      accept, push, full, pop, head_valid;
  a2lp_cmd_t cmd, head;
  a2lp_res_t res;

  // front end takes a byte whenever the command queue has room
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  a2lp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .stream_byte_i (s_axis_tdata),
    .frame_end_i   (s_axis_tlast),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  a2lp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  a2lp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  // pack result fields onto the bus
  assign m_axis_tdata = {2'b00, res.over, res.value, res.offset};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
